### hdl/minimum_image_pair_distance_assert.svh
// assertion macros for the pair distance checker
`ifndef MINIMUM_IMAGE_PAIR_DISTANCE_ASSERT_SVH
`define MINIMUM_IMAGE_PAIR_DISTANCE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MIPD_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pair distance check failed");

// next-cycle implication, quiet during reset
`define MIPD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pair distance check failed");

// implication that also covers the reset release
`define MIPD_ASSERT_RAW(label, pre, post) \
    label: assert property (@(posedge clk) (pre) |-> (post)) \
        else $error("pair distance check failed");

`endif

### hdl/mipd_pkg.sv
package mipd_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int BOX_W   = 31;
    localparam int SQ_W    = 66;
    localparam int ROOT_W  = 33;
    localparam int REM_W   = 35;

    // one quotient bit per stage, one root bit per stage
    localparam int MOD_STAGES  = DIFF_W;
    localparam int ROOT_STAGES = ROOT_W;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = BOX_W;

    localparam logic [CFG_INDEX_W-1:0] REG_BOX_LENGTH      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIODIC_ENABLE = 1'b1;

    localparam logic [BOX_W-1:0] BOX_LENGTH_RESET      = 31'd655360;
    localparam logic             PERIODIC_ENABLE_RESET = 1'b1;

    // fold: input stage, remainder stages, fold stage
    localparam int FOLD_LAT = MOD_STAGES + 2;
    // magnitude and square stages between fold and root
    localparam int MID_LAT  = 2;
    // sum register plus one register per root bit
    localparam int ROOT_LAT = ROOT_STAGES + 1;
    localparam int LATENCY  = FOLD_LAT + MID_LAT + ROOT_LAT;

endpackage

### hdl/mipd_fold.sv
module mipd_fold
(
    input  logic                               clk,
    input  logic                               advance,
    input  logic signed [mipd_pkg::COORD_W-1:0] first,
    input  logic signed [mipd_pkg::COORD_W-1:0] second,
    input  logic        [mipd_pkg::BOX_W-1:0]   box_length,
    input  logic                               periodic_enable,
    output logic signed [mipd_pkg::DIFF_W-1:0]  sep
);

    localparam int N = mipd_pkg::MOD_STAGES;
    localparam int DW = mipd_pkg::DIFF_W;
    localparam int BW = mipd_pkg::BOX_W;

    logic [DW-1:0] mag_reg [0:N];
    logic [BW-1:0] rem_reg [0:N];
    logic [DW-1:0] diff_reg [0:N];
    logic          neg_reg [0:N];
    logic          bypass_reg [0:N];
    logic signed [DW-1:0] sep_reg;

    logic [DW-1:0] diff_next;

    assign diff_next = {second[mipd_pkg::COORD_W-1], second}
                     - {first[mipd_pkg::COORD_W-1], first};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff_reg[0]   <= diff_next;
            neg_reg[0]    <= diff_next[DW-1];
            mag_reg[0]    <= diff_next[DW-1] ? (DW'(0) - diff_next) : diff_next;
            bypass_reg[0] <= !periodic_enable || (box_length == '0);
            rem_reg[0]    <= '0;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [BW:0]   trial;
        logic [BW-1:0] rem_next;

        always_comb
        begin
            trial = {rem_reg[k], mag_reg[k][DW-1-k]};
            if (trial >= {1'b0, box_length})
            begin
                rem_next = BW'(trial - {1'b0, box_length});
            end
            else
            begin
                rem_next = trial[BW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k+1]    <= rem_next;
                mag_reg[k+1]    <= mag_reg[k];
                diff_reg[k+1]   <= diff_reg[k];
                neg_reg[k+1]    <= neg_reg[k];
                bypass_reg[k+1] <= bypass_reg[k];
            end
        end
    end

    logic [DW-1:0] folded;
    logic [DW-1:0] sep_next;

    always_comb
    begin
        if ({rem_reg[N], 1'b0} >= {1'b0, box_length})
        begin
            folded = {2'b00, rem_reg[N]} - {2'b00, box_length};
        end
        else
        begin
            folded = {2'b00, rem_reg[N]};
        end
        if (bypass_reg[N])
        begin
            sep_next = diff_reg[N];
        end
        else if (neg_reg[N])
        begin
            sep_next = DW'(0) - folded;
        end
        else
        begin
            sep_next = folded;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sep_reg <= sep_next;
        end
    end

    assign sep = sep_reg;

endmodule

### hdl/mipd_sqrt.sv
module mipd_sqrt
(
    input  logic                          clk,
    input  logic                          advance,
    input  logic [mipd_pkg::SQ_W-1:0]     radicand,
    output logic [mipd_pkg::ROOT_W-1:0]   root
);

    localparam int N  = mipd_pkg::ROOT_STAGES;
    localparam int SW = mipd_pkg::SQ_W;
    localparam int RW = mipd_pkg::ROOT_W;
    localparam int MW = mipd_pkg::REM_W;

    logic [SW-1:0] rad_reg  [0:N];
    logic [MW-1:0] rem_reg  [0:N];
    logic [RW-1:0] root_reg [0:N];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rad_reg[0]  <= radicand;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [MW+1:0] work;
        logic [MW+1:0] trial;
        logic [MW-1:0] rem_next;
        logic          bit_next;

        always_comb
        begin
            work  = {rem_reg[k], rad_reg[k][SW-1 -: 2]};
            trial = {2'b00, root_reg[k], 2'b01};
            if (work >= trial)
            begin
                rem_next = MW'(work - trial);
                bit_next = 1'b1;
            end
            else
            begin
                rem_next = work[MW-1:0];
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rad_reg[k+1]  <= {rad_reg[k][SW-3:0], 2'b00};
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= {root_reg[k][RW-2:0], bit_next};
            end
        end
    end

    assign root = root_reg[N];

endmodule

### hdl/minimum_image_pair_distance.sv
// path: an accepted input word passes the fold, magnitude, square and root registers before its result word is shown
// throughput: one pair per cycle while no waiting result stalls, remainder and root pipelines take one bit per stage
// a stalled result holds the whole pipeline, nothing is dropped or repeated
// reset: asynchronous active low, clears valid bits, box length 10.0, periodic mode on
module minimum_image_pair_distance
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [mipd_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [mipd_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [mipd_pkg::COORD_W-1:0]      first_x,
    input  logic signed [mipd_pkg::COORD_W-1:0]      first_y,
    input  logic signed [mipd_pkg::COORD_W-1:0]      first_z,
    input  logic signed [mipd_pkg::COORD_W-1:0]      second_x,
    input  logic signed [mipd_pkg::COORD_W-1:0]      second_y,
    input  logic signed [mipd_pkg::COORD_W-1:0]      second_z,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [mipd_pkg::DIFF_W-1:0]       sep_x,
    output logic signed [mipd_pkg::DIFF_W-1:0]       sep_y,
    output logic signed [mipd_pkg::DIFF_W-1:0]       sep_z,
    output logic        [mipd_pkg::ROOT_W-1:0]       distance
);

    localparam int LAT = mipd_pkg::LATENCY;
    localparam int DW  = mipd_pkg::DIFF_W;
    localparam int SW  = mipd_pkg::SQ_W;
    localparam int SEP_DLY = mipd_pkg::MID_LAT + mipd_pkg::ROOT_LAT;

    logic [mipd_pkg::BOX_W-1:0] box_length_reg;
    logic                       periodic_enable_reg;
    logic [LAT-1:0]             valid_reg;
    logic                       advance;

    assign advance   = !valid_reg[LAT-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_length_reg      <= mipd_pkg::BOX_LENGTH_RESET;
            periodic_enable_reg <= mipd_pkg::PERIODIC_ENABLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mipd_pkg::REG_BOX_LENGTH:      box_length_reg <= cfg_wdata;
                mipd_pkg::REG_PERIODIC_ENABLE: periodic_enable_reg <= cfg_wdata[0];
                default:                       box_length_reg <= box_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    logic signed [DW-1:0] sep_lane [0:2];

    mipd_fold u_fold_x
    (
        .clk             (clk),
        .advance         (advance),
        .first           (first_x),
        .second          (second_x),
        .box_length      (box_length_reg),
        .periodic_enable (periodic_enable_reg),
        .sep             (sep_lane[0])
    );

    mipd_fold u_fold_y
    (
        .clk             (clk),
        .advance         (advance),
        .first           (first_y),
        .second          (second_y),
        .box_length      (box_length_reg),
        .periodic_enable (periodic_enable_reg),
        .sep             (sep_lane[1])
    );

    mipd_fold u_fold_z
    (
        .clk             (clk),
        .advance         (advance),
        .first           (first_z),
        .second          (second_z),
        .box_length      (box_length_reg),
        .periodic_enable (periodic_enable_reg),
        .sep             (sep_lane[2])
    );

    logic [DW-1:0] mag_reg [0:2];
    logic [SW-1:0] sq_reg  [0:2];

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        logic [DW-1:0] sep_dly_reg [0:SEP_DLY-1];

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                mag_reg[c] <= sep_lane[c][DW-1] ? (DW'(0) - sep_lane[c]) : sep_lane[c];
                sq_reg[c]  <= SW'(mag_reg[c]) * SW'(mag_reg[c]);
                sep_dly_reg[0] <= sep_lane[c];
                for (int i = 1; i < SEP_DLY; i++)
                begin
                    sep_dly_reg[i] <= sep_dly_reg[i-1];
                end
            end
        end

        if (c == 0)
        begin : g_out_x
            assign sep_x = sep_dly_reg[SEP_DLY-1];
        end
        else if (c == 1)
        begin : g_out_y
            assign sep_y = sep_dly_reg[SEP_DLY-1];
        end
        else
        begin : g_out_z
            assign sep_z = sep_dly_reg[SEP_DLY-1];
        end
    end

    logic [SW-1:0] sum_sq;

    assign sum_sq = sq_reg[0] + sq_reg[1] + sq_reg[2];

    mipd_sqrt u_sqrt
    (
        .clk      (clk),
        .advance  (advance),
        .radicand (sum_sq),
        .root     (distance)
    );

endmodule

### hdl/mipd_checker.sv
`include "minimum_image_pair_distance_assert.svh"

module mipd_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [mipd_pkg::DIFF_W-1:0] sep_x,
    input logic        [mipd_pkg::ROOT_W-1:0] distance
);

    // a held result keeps its sep_x and distance
    `MIPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sep_x) && $stable(distance))

    // input side is stalled only by a waiting result
    `MIPD_ASSERT_NOW(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready))

    // a stalled input word cannot be taken
    `MIPD_ASSERT_NOW(a_stall_blocks, in_valid && out_valid && !out_ready, !in_ready)

    // nothing comes out right after reset
    `MIPD_ASSERT_RAW(a_reset_empty, $rose(rst_n), !out_valid)

endmodule

bind minimum_image_pair_distance mipd_checker u_mipd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sep_x     (sep_x),
    .distance  (distance)
);

### test/tb_minimum_image_pair_distance.sv
`timescale 1ns / 1ps

module tb_minimum_image_pair_distance;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = mipd_pkg::LATENCY + 10;

    typedef struct {
        logic signed [mipd_pkg::COORD_W-1:0] ax, ay, az, bx, by, bz;
    } pair_t;

    typedef struct {
        logic signed [mipd_pkg::DIFF_W-1:0] sx, sy, sz;
        logic [mipd_pkg::ROOT_W-1:0]        span;
    } sep_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [mipd_pkg::CFG_INDEX_W-1:0] cfg_index = mipd_pkg::REG_BOX_LENGTH;
    logic [mipd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [mipd_pkg::COORD_W-1:0] first_x = '0, first_y = '0, first_z = '0;
    logic signed [mipd_pkg::COORD_W-1:0] second_x = '0, second_y = '0, second_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [mipd_pkg::DIFF_W-1:0] sep_x, sep_y, sep_z;
    logic [mipd_pkg::ROOT_W-1:0] distance;

    minimum_image_pair_distance dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow of the block's registers
    logic [mipd_pkg::BOX_W-1:0] box_len = mipd_pkg::BOX_LENGTH_RESET;
    logic                       fold_on = mipd_pkg::PERIODIC_ENABLE_RESET;

    pair_t pending_pairs[$];
    sep_t  expected_seps[$];
    int    errors = 0;
    int    pairs_sent = 0;
    int    pairs_taken = 0;
    int    seps_checked = 0;
    int    cycles = 0;
    int    ties_seen = 0;

    function automatic logic signed [mipd_pkg::DIFF_W-1:0] fold_component(
        logic signed [mipd_pkg::COORD_W-1:0] a, logic signed [mipd_pkg::COORD_W-1:0] b);
        logic signed [63:0] sa, sb, d, f;
        logic [63:0] mag, len, r;
        sa = a;
        sb = b;
        d = sb - sa;
        if (!fold_on || box_len == '0)
            return d[mipd_pkg::DIFF_W-1:0];
        mag = d[63] ? -d : d;
        len = {33'd0, box_len};
        r = mag % len;
        if (2 * r >= len)
            f = $signed(r) - $signed(len);
        else
            f = $signed(r);
        if (d[63])
            f = -f;
        return f[mipd_pkg::DIFF_W-1:0];
    endfunction

    function automatic sep_t pair_separation(pair_t p);
        sep_t s;
        logic [mipd_pkg::SQ_W+1:0] sum, sq;
        logic [mipd_pkg::SQ_W+1:0] m;
        logic [mipd_pkg::ROOT_W-1:0] root, cand;
        logic signed [mipd_pkg::DIFF_W-1:0] c[3];
        s.sx = fold_component(p.ax, p.bx);
        s.sy = fold_component(p.ay, p.by);
        s.sz = fold_component(p.az, p.bz);
        c[0] = s.sx;
        c[1] = s.sy;
        c[2] = s.sz;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            m = c[k][mipd_pkg::DIFF_W-1] ? {35'd0, -c[k]} : {35'd0, c[k]};
            sum = sum + m * m;
        end
        root = '0;
        for (int i = mipd_pkg::ROOT_W - 1; i >= 0; i--)
        begin
            cand = root | (mipd_pkg::ROOT_W'(1) << i);
            sq = {35'd0, cand} * {35'd0, cand};
            if (sq <= sum)
                root = cand;
        end
        s.span = root;
        return s;
    endfunction

    // input side: accepted words become expectations
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
        begin
            pair_t p;
            p = '{first_x, first_y, first_z, second_x, second_y, second_z};
            expected_seps = {expected_seps, pair_separation(p)};
            pairs_taken <= pairs_taken + 1;
        end
    end

    // driver: bursts with random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && pairs_taken != pairs_sent))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                pair_t p;
                p = pending_pairs.pop_front();
                first_x <= p.ax; first_y <= p.ay; first_z <= p.az;
                second_x <= p.bx; second_y <= p.by; second_z <= p.bz;
                in_valid <= 1'b1;
                pairs_sent <= pairs_sent + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: own stall pattern plus one long hold-off
    int hold_left = 0;
    bit hold_done = 0;
    int stall_mode = 0;
    always @(negedge clk)
    begin
        if (!hold_done && pairs_taken >= 100)
        begin
            hold_done <= 1;
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sep_t e;
            if (expected_seps.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
            end
            else
            begin
                e = expected_seps.pop_front();
                seps_checked++;
                if (sep_x !== e.sx)
                begin
                    $error("sep_x expected %0d actual %0d", e.sx, sep_x);
                    errors++;
                end
                if (sep_y !== e.sy)
                begin
                    $error("sep_y expected %0d actual %0d", e.sy, sep_y);
                    errors++;
                end
                if (sep_z !== e.sz)
                begin
                    $error("sep_z expected %0d actual %0d", e.sz, sep_z);
                    errors++;
                end
                if (distance !== e.span)
                begin
                    $error("distance expected %0d actual %0d", e.span, distance);
                    errors++;
                end
            end
        end
    end

    task automatic add_pair(logic signed [31:0] ax, ay, az, bx, by, bz);
        pair_t p;
        p = '{ax, ay, az, bx, by, bz};
        pending_pairs = {pending_pairs, p};
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000000)) - 1000000;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 70000)
                                          : 32'sh80000000 + $urandom_range(0, 70000);
            default: return $signed({$urandom_range(0, 65535), 16'h0});
        endcase
    endfunction

    task automatic add_random(int n);
        logic signed [31:0] a, h;
        for (int i = 0; i < n; i++)
        begin
            pair_t p;
            p.ax = rand_coord(); p.ay = rand_coord(); p.az = rand_coord();
            p.bx = rand_coord(); p.by = rand_coord(); p.bz = rand_coord();
            // sometimes place a component exactly on a half-box tie
            if ($urandom_range(0, 7) == 0 && box_len[0] == 1'b0)
            begin
                h = $signed({1'b0, box_len}) >>> 1;
                a = $signed($urandom_range(0, 1000000));
                p.ax = a;
                p.bx = $urandom_range(0, 1) ? a + h : a - h;
                ties_seen++;
            end
            pending_pairs = {pending_pairs, p};
        end
    endtask

    task automatic wait_idle();
        do
        begin
            wait (pending_pairs.size() == 0 && pairs_taken == pairs_sent
                  && expected_seps.size() == 0);
            @(negedge clk);
        end
        while (!(pending_pairs.size() == 0 && pairs_taken == pairs_sent
                 && expected_seps.size() == 0));
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [mipd_pkg::CFG_INDEX_W-1:0] idx,
                             logic [mipd_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == mipd_pkg::REG_BOX_LENGTH)
            box_len = val;
        else
            fold_on = val[0];
    endtask

    task automatic set_config(logic [mipd_pkg::BOX_W-1:0] b, logic p);
        wait_idle();
        write_reg(mipd_pkg::REG_BOX_LENGTH, b);
        write_reg(mipd_pkg::REG_PERIODIC_ENABLE, mipd_pkg::CFG_DATA_W'(p));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: box 10.0, folding on
        add_pair(0, 0, 0, 0, 0, 0);
        add_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_pair(0, 0, 0, 327680, -327680, 655360);
        add_pair(100, 200, 300, 100 + 327680, 200 - 327680, 300 - 655360);
        add_pair(0, 0, 0, 983040, -983040, 327679);
        add_pair(-1, 1, 0, 1, -1, 32'sh7fffffff);
        add_pair(65536, 131072, 196608, -65536, -131072, -196608);
        add_random(80);

        set_config(31'd655360, 1'b0);
        add_pair(32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000);
        add_pair(0, 0, 0, 327680, -327680, 655360);
        add_random(80);

        set_config(31'd1, 1'b1);
        add_pair(0, 5, -5, 1, -7, 32'sh7fffffff);
        add_random(80);

        set_config(31'h7fffffff, 1'b1);
        add_pair(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh80000000, 0);
        add_pair(0, 0, 0, 32'sh40000000, 32'shc0000000, 32'sh3fffffff);
        add_random(80);

        // zero box: plain difference despite folding on
        set_config(31'd0, 1'b1);
        add_pair(32'sh80000000, 0, 0, 32'sh7fffffff, 1, -1);
        add_random(60);

        set_config(31'd2, 1'b1);
        add_pair(0, 1, -1, 1, 0, 0);
        add_random(60);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_config(mipd_pkg::BOX_W'(($urandom_range(0, 1) ? $urandom_range(1, 1 << 22)
                                         : $urandom_range(1, 32'h7fffffff)) & ~32'd1),
                       $urandom_range(0, 3) != 0);
            add_random(60);
        end

        set_config(31'd3, 1'b1);
        add_random(40);

        wait_idle();
        $display("pairs checked: %0d, half-box ties placed: %0d, cycles: %0d",
                 seps_checked, ties_seen, cycles);
        $display("settings covered: box 0, 1, 2, 3, 10.0, maximum and random; folding on and off");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### minimum_image_pair_distance.f
+incdir+hdl
hdl/mipd_pkg.sv
hdl/mipd_fold.sv
hdl/mipd_sqrt.sv
hdl/minimum_image_pair_distance.sv
hdl/mipd_checker.sv
test/tb_minimum_image_pair_distance.sv
